/* rtl/core/hbr_pkg.sv */
package hbr_pkg;

  localparam int KEY_SLOTS = 6;
  localparam int MOD_KEYS  = 6;
  localparam int USAGE_W   = 8;
  localparam int SCAN_W    = 7;
  localparam int STEP_W    = 3;

  // Table entry: bit 7 is the E0 flag, bits 6:0 the make code, zero means unmapped.
  localparam logic [7:0] EXT_FLAG = 8'h80;

  function automatic logic [7:0] usage_lookup(input logic [USAGE_W-1:0] usage);
    logic [7:0] e;
    case (usage)
      8'h04: e = 8'h1E;  8'h05: e = 8'h30;  8'h06: e = 8'h2E;  8'h07: e = 8'h20;
      8'h08: e = 8'h12;  8'h09: e = 8'h21;  8'h0A: e = 8'h22;  8'h0B: e = 8'h23;
      8'h0C: e = 8'h17;  8'h0D: e = 8'h24;  8'h0E: e = 8'h25;  8'h0F: e = 8'h26;
      8'h10: e = 8'h32;  8'h11: e = 8'h31;  8'h12: e = 8'h18;  8'h13: e = 8'h19;
      8'h14: e = 8'h10;  8'h15: e = 8'h13;  8'h16: e = 8'h1F;  8'h17: e = 8'h14;
      8'h18: e = 8'h16;  8'h19: e = 8'h2F;  8'h1A: e = 8'h11;  8'h1B: e = 8'h2D;
      8'h1C: e = 8'h15;  8'h1D: e = 8'h2C;
      8'h1E: e = 8'h02;  8'h1F: e = 8'h03;  8'h20: e = 8'h04;  8'h21: e = 8'h05;
      8'h22: e = 8'h06;  8'h23: e = 8'h07;  8'h24: e = 8'h08;  8'h25: e = 8'h09;
      8'h26: e = 8'h0A;  8'h27: e = 8'h0B;
      8'h28: e = 8'h1C;  8'h29: e = 8'h01;  8'h2A: e = 8'h0E;  8'h2B: e = 8'h0F;
      8'h2C: e = 8'h39;
      8'h2D: e = 8'h0C;  8'h2E: e = 8'h0D;  8'h2F: e = 8'h1A;  8'h30: e = 8'h1B;
      8'h31: e = 8'h2B;  8'h33: e = 8'h27;  8'h34: e = 8'h28;  8'h35: e = 8'h29;
      8'h36: e = 8'h33;  8'h37: e = 8'h34;  8'h38: e = 8'h35;
      8'h39: e = 8'h3A;
      8'h3A: e = 8'h3B;  8'h3B: e = 8'h3C;  8'h3C: e = 8'h3D;  8'h3D: e = 8'h3E;
      8'h3E: e = 8'h3F;  8'h3F: e = 8'h40;  8'h40: e = 8'h41;  8'h41: e = 8'h42;
      8'h42: e = 8'h43;  8'h43: e = 8'h44;  8'h44: e = 8'h57;  8'h45: e = 8'h58;
      8'h46: e = 8'h37;  8'h47: e = 8'h46;
      8'h49: e = EXT_FLAG | 8'h52;  8'h4A: e = EXT_FLAG | 8'h47;
      8'h4B: e = EXT_FLAG | 8'h49;  8'h4C: e = EXT_FLAG | 8'h53;
      8'h4D: e = EXT_FLAG | 8'h4F;  8'h4E: e = EXT_FLAG | 8'h51;
      8'h4F: e = EXT_FLAG | 8'h4D;  8'h50: e = EXT_FLAG | 8'h4B;
      8'h51: e = EXT_FLAG | 8'h50;  8'h52: e = EXT_FLAG | 8'h48;
      default: e = 8'h00;
    endcase
    return e;
  endfunction

  // Modifier keys in emission order: LCtrl, LShift, LAlt, RCtrl, RShift, RAlt.
  function automatic logic [2:0] mod_bit_pos(input logic [STEP_W-1:0] idx);
    logic [2:0] p;
    case (idx)
      3'd0:    p = 3'd0;
      3'd1:    p = 3'd1;
      3'd2:    p = 3'd2;
      3'd3:    p = 3'd4;
      3'd4:    p = 3'd5;
      default: p = 3'd6;
    endcase
    return p;
  endfunction

  function automatic logic [7:0] mod_entry(input logic [STEP_W-1:0] idx);
    logic [7:0] e;
    case (idx)
      3'd0:    e = 8'h1D;
      3'd1:    e = 8'h2A;
      3'd2:    e = 8'h38;
      3'd3:    e = EXT_FLAG | 8'h1D;
      3'd4:    e = 8'h36;
      default: e = EXT_FLAG | 8'h38;
    endcase
    return e;
  endfunction

endpackage

/* rtl/core/hbr_if.sv */
interface hbr_in_if;
  import hbr_pkg::*;

  logic               valid;
  logic               ready;
  logic [USAGE_W-1:0] modifier_bits;
  logic [USAGE_W-1:0] key_slot0;
  logic [USAGE_W-1:0] key_slot1;
  logic [USAGE_W-1:0] key_slot2;
  logic [USAGE_W-1:0] key_slot3;
  logic [USAGE_W-1:0] key_slot4;
  logic [USAGE_W-1:0] key_slot5;

  modport source (
    output valid, modifier_bits, key_slot0, key_slot1, key_slot2, key_slot3,
           key_slot4, key_slot5,
    input  ready
  );
  modport sink (
    input  valid, modifier_bits, key_slot0, key_slot1, key_slot2, key_slot3,
           key_slot4, key_slot5,
    output ready
  );
endinterface

interface hbr_out_if;
  import hbr_pkg::*;

  logic              valid;
  logic              ready;
  logic [SCAN_W-1:0] scan_code;
  logic              is_extended;
  logic              is_press;
  logic              last_event;

  modport source (
    output valid, scan_code, is_extended, is_press, last_event,
    input  ready
  );
  modport sink (
    input  valid, scan_code, is_extended, is_press, last_event,
    output ready
  );
endinterface

/* rtl/core/hid_boot_report_to_set1_scancodes.sv */
// Channel   Interface         Dir  Transaction
// in_ch     hbr_in_if.sink    in   one boot report: modifier byte and six usage slots
// out_ch    hbr_out_if.source out  one key event: set-1 code, E0 flag, make/break, last
//
// A report takes an accept step, 6 modifier steps, 6 release steps, 6 press steps
// and 1 closing step. One shared compare unit (usage against the six slots of the
// other report, plus the usage table) is stepped by the sequencer once per slot.
// in_ch.ready is high only while the sequencer is idle.
// A back-pressured output holds the sequencer only when a new event finds both
// the output register and the one-deep pending register full, or when the
// closing step still holds an event and the output register is full.
// rst_n is synchronous: it clears the held report to "no keys, no modifiers".
module hid_boot_report_to_set1_scancodes (
  input logic clk,
  input logic rst_n,
  hbr_in_if.sink    in_ch,
  hbr_out_if.source out_ch
);
  import hbr_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_REL,
    ST_PRS,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic [SCAN_W-1:0] scan_code;
    logic              is_extended;
    logic              is_press;
  } event_t;

  localparam logic [STEP_W-1:0] MOD_LAST  = STEP_W'(MOD_KEYS - 1);
  localparam logic [STEP_W-1:0] SLOT_LAST = STEP_W'(KEY_SLOTS - 1);

  state_t              state_r;
  logic [STEP_W-1:0]   idx_r;

  // Previous report and the report in work
  logic [USAGE_W-1:0]  prev_mods_r;
  logic [USAGE_W-1:0]  prev_keys_r [KEY_SLOTS];
  logic [USAGE_W-1:0]  cur_mods_r;
  logic [USAGE_W-1:0]  cur_keys_r  [KEY_SLOTS];

  // One event held back until we know whether it is the last one
  event_t              pend_r;
  logic                pend_vld_r;

  event_t              out_r;
  logic                out_last_r;
  logic                out_vld_r;

  // Shared compare unit
  logic [USAGE_W-1:0]  key_sel;
  logic                found;
  logic [7:0]          entry;
  logic [7:0]          mod_ent;
  logic                mod_was;
  logic                mod_is;
  logic                hit;
  event_t              ev;
  logic                out_free;
  logic                stall;
  logic                phase_end;
  logic                out_load;

  assign out_free = !out_vld_r || out_ch.ready;

  always_comb begin
    // Release pass looks up old keys in the new report; press pass the reverse.
    key_sel = (state_r == ST_PRS) ? cur_keys_r[idx_r] : prev_keys_r[idx_r];
    found   = 1'b0;
    for (int j = 0; j < KEY_SLOTS; j++) begin
      if (state_r == ST_PRS) begin
        found = found | (prev_keys_r[j] == key_sel);
      end else begin
        found = found | (cur_keys_r[j] == key_sel);
      end
    end
    entry   = usage_lookup(key_sel);
    mod_ent = mod_entry(idx_r);
    mod_was = prev_mods_r[mod_bit_pos(idx_r)];
    mod_is  = cur_mods_r[mod_bit_pos(idx_r)];

    hit = 1'b0;
    ev  = '0;
    unique case (state_r) inside
      ST_MOD: begin
        hit            = mod_was != mod_is;
        ev.scan_code   = mod_ent[SCAN_W-1:0];
        ev.is_extended = mod_ent[7];
        ev.is_press    = mod_is;
      end
      ST_REL, ST_PRS: begin
        // Skip empty slots, keys still held and usages with no set-1 code
        hit            = (key_sel != '0) && !found && (entry != 8'h00);
        ev.scan_code   = entry[SCAN_W-1:0];
        ev.is_extended = entry[7];
        ev.is_press    = state_r == ST_PRS;
      end
      default: begin
        hit = 1'b0;
      end
    endcase

    stall     = hit && pend_vld_r && !out_free;
    phase_end = (state_r == ST_MOD) ? (idx_r == MOD_LAST) : (idx_r == SLOT_LAST);

    // Push the pending event into the output register
    out_load = 1'b0;
    if (state_r == ST_FIN) begin
      out_load = pend_vld_r && out_free;
    end else if (state_r != ST_IDLE) begin
      out_load = hit && pend_vld_r && out_free;
    end
  end

  assign in_ch.ready        = state_r == ST_IDLE;
  assign out_ch.valid       = out_vld_r;
  assign out_ch.scan_code   = out_r.scan_code;
  assign out_ch.is_extended = out_r.is_extended;
  assign out_ch.is_press    = out_r.is_press;
  assign out_ch.last_event  = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      prev_mods_r <= '0;
      for (int i = 0; i < KEY_SLOTS; i++) begin
        prev_keys_r[i] <= '0;
      end
      pend_vld_r  <= 1'b0;
      out_vld_r   <= 1'b0;
    end else begin
      unique case (state_r) inside
        ST_IDLE: begin
          if (in_ch.valid) begin
            cur_mods_r    <= in_ch.modifier_bits;
            cur_keys_r[0] <= in_ch.key_slot0;
            cur_keys_r[1] <= in_ch.key_slot1;
            cur_keys_r[2] <= in_ch.key_slot2;
            cur_keys_r[3] <= in_ch.key_slot3;
            cur_keys_r[4] <= in_ch.key_slot4;
            cur_keys_r[5] <= in_ch.key_slot5;
            idx_r         <= '0;
            state_r       <= ST_MOD;
          end
        end
        ST_MOD, ST_REL, ST_PRS: begin
          if (!stall) begin
            if (hit) begin
              // Push the held event out, hold the new one
              if (pend_vld_r) begin
                out_r      <= pend_r;
                out_last_r <= 1'b0;
              end
              pend_r     <= ev;
              pend_vld_r <= 1'b1;
            end
            if (phase_end) begin
              idx_r <= '0;
              if (state_r == ST_MOD) begin
                state_r <= ST_REL;
              end else if (state_r == ST_REL) begin
                state_r <= ST_PRS;
              end else begin
                state_r <= ST_FIN;
              end
            end else begin
              idx_r <= idx_r + STEP_W'(1);
            end
          end
        end
        ST_FIN: begin
          // Flush the final event flagged as last, then retire the report
          if (!pend_vld_r || out_free) begin
            if (pend_vld_r) begin
              out_r      <= pend_r;
              out_last_r <= 1'b1;
              pend_vld_r <= 1'b0;
            end
            prev_mods_r <= cur_mods_r;
            for (int i = 0; i < KEY_SLOTS; i++) begin
              prev_keys_r[i] <= cur_keys_r[i];
            end
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase

      // Load the output register on a push, else drop the transaction once taken
      if (out_load) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // An accepted report always starts at the first modifier step
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (state_r == ST_MOD && idx_r == '0))
    else $error("report did not start at first modifier step");

  // No event is left pending while the block takes a new report
  a_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !pend_vld_r)
    else $error("pending event left over at idle");

  // Closing step with nothing pending returns to idle right away
  a_fin_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && !pend_vld_r) |=> in_ch.ready)
    else $error("closing step stuck with no pending event");

endmodule

/* dv/hid_boot_report_to_set1_scancodes_tb.sv */
`timescale 1ns / 100ps

module hid_boot_report_to_set1_scancodes_tb;
  import hbr_pkg::*;

  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 60;
  localparam int unsigned IDLE_PCT     = 37;

  // Modifier keys in the order the block reports their edges:
  // LCtrl, LShift, LAlt, RCtrl, RShift, RAlt. GUI bits 3 and 7 never show up.
  localparam int         MOD_POS  [MOD_KEYS] = '{0, 1, 2, 4, 5, 6};
  localparam logic [7:0] MOD_CODE [MOD_KEYS] = '{
    8'h1D, 8'h2A, 8'h38, EXT_FLAG | 8'h1D, 8'h36, EXT_FLAG | 8'h38
  };

  // Set-1 make codes of the letter usages A..Z (0x04..0x1D).
  localparam logic [7:0] LETTER_CODES [26] = '{
    8'h1E, 8'h30, 8'h2E, 8'h20, 8'h12, 8'h21, 8'h22, 8'h23, 8'h17, 8'h24,
    8'h25, 8'h26, 8'h32, 8'h31, 8'h18, 8'h19, 8'h10, 8'h13, 8'h1F, 8'h14,
    8'h16, 8'h2F, 8'h11, 8'h2D, 8'h15, 8'h2C
  };
  // Insert, Home, PgUp, Delete, End, PgDn, Right, Left, Down, Up (0x49..0x52),
  // all of them behind the E0 prefix.
  localparam logic [7:0] NAV_CODES [10] = '{
    8'h52, 8'h47, 8'h49, 8'h53, 8'h4F, 8'h51, 8'h4D, 8'h4B, 8'h50, 8'h48
  };

  typedef struct packed {
    logic [USAGE_W-1:0]                  mods;
    logic [KEY_SLOTS-1:0][USAGE_W-1:0]   slots;
  } report_t;

  typedef struct packed {
    logic [SCAN_W-1:0] scan_code;
    logic              is_extended;
    logic              is_press;
    logic              last_event;
  } key_event_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  hbr_in_if  in_bus ();
  hbr_out_if out_bus ();

  hid_boot_report_to_set1_scancodes u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  always #5 clk = ~clk;

  // Usage -> set-1 entry: bit 7 the E0 flag, bits 6:0 the make code, 0 unmapped.
  logic [7:0] set1_map [256];

  // Key state as seen by the host after each accepted report.
  logic [USAGE_W-1:0]                held_mods;
  logic [KEY_SLOTS-1:0][USAGE_W-1:0] held_keys;
  report_t                           last_sent;

  key_event_t  pending_events [$];
  int unsigned mismatches = 0;

  // Idling control: steady switches off random gaps on both sides; a hold request
  // makes the receiver refuse every transaction until its countdown from HOLD_CYCLES ends.
  bit          steady        = 1'b0;
  int unsigned hold_requests = 0;
  int unsigned holds_taken   = 0;
  int unsigned hold_left     = 0;

  initial begin
    foreach (set1_map[u]) set1_map[u] = 8'h00;
    for (int i = 0; i < 26; i++) set1_map[8'(8'h04 + i)] = LETTER_CODES[i];
    // Digits 1..0 and F1..F10 run in step with their make codes.
    for (int i = 0; i < 10; i++) set1_map[8'(8'h1E + i)] = 8'(8'h02 + i);
    for (int i = 0; i < 10; i++) set1_map[8'(8'h3A + i)] = 8'(8'h3B + i);
    for (int i = 0; i < 10; i++) set1_map[8'(8'h49 + i)] = EXT_FLAG | NAV_CODES[i];
    set1_map[8'h28] = 8'h1C;  set1_map[8'h29] = 8'h01;  set1_map[8'h2A] = 8'h0E;
    set1_map[8'h2B] = 8'h0F;  set1_map[8'h2C] = 8'h39;  set1_map[8'h2D] = 8'h0C;
    set1_map[8'h2E] = 8'h0D;  set1_map[8'h2F] = 8'h1A;  set1_map[8'h30] = 8'h1B;
    set1_map[8'h31] = 8'h2B;  set1_map[8'h33] = 8'h27;  set1_map[8'h34] = 8'h28;
    set1_map[8'h35] = 8'h29;  set1_map[8'h36] = 8'h33;  set1_map[8'h37] = 8'h34;
    set1_map[8'h38] = 8'h35;  set1_map[8'h39] = 8'h3A;  set1_map[8'h44] = 8'h57;
    set1_map[8'h45] = 8'h58;  set1_map[8'h46] = 8'h37;  set1_map[8'h47] = 8'h46;
  end

  function automatic bit slot_holds(logic [KEY_SLOTS-1:0][USAGE_W-1:0] slots,
                                    logic [USAGE_W-1:0] usage);
    foreach (slots[j]) if (slots[j] == usage) return 1'b1;
    return 1'b0;
  endfunction

  // Work out the key events one report causes against the held state, queue
  // them in emission order and advance the held state.
  function automatic void predict_key_events(report_t r);
    key_event_t         evs [$];
    logic [7:0]         entry;
    logic [USAGE_W-1:0] usage;
    logic               now_on;
    for (int m = 0; m < MOD_KEYS; m++) begin
      now_on = r.mods[MOD_POS[m]];
      if (held_mods[MOD_POS[m]] != now_on)
        evs.push_back('{MOD_CODE[m][6:0], MOD_CODE[m][7], now_on, 1'b0});
    end
    // Releases: held usages gone from every slot of the new report.
    for (int i = 0; i < KEY_SLOTS; i++) begin
      usage = held_keys[i];
      entry = set1_map[usage];
      if (usage != 0 && entry != 0 && !slot_holds(r.slots, usage))
        evs.push_back('{entry[6:0], entry[7], 1'b0, 1'b0});
    end
    // Presses: new usages absent from every slot of the held report.
    for (int i = 0; i < KEY_SLOTS; i++) begin
      usage = r.slots[i];
      entry = set1_map[usage];
      if (usage != 0 && entry != 0 && !slot_holds(held_keys, usage))
        evs.push_back('{entry[6:0], entry[7], 1'b1, 1'b0});
    end
    if (evs.size() > 0) evs[evs.size() - 1].last_event = 1'b1;
    foreach (evs[e]) pending_events.push_back(evs[e]);
    held_mods = r.mods;
    held_keys = r.slots;
  endfunction

  function automatic report_t report(logic [7:0] mods, logic [7:0] s0, logic [7:0] s1,
                                     logic [7:0] s2, logic [7:0] s3, logic [7:0] s4,
                                     logic [7:0] s5);
    report_t r;
    r.mods  = mods;
    r.slots = {s5, s4, s3, s2, s1, s0};
    return r;
  endfunction

  // Offer one report and hold it until the block takes it. Valid stays high after
  // the transaction so back-to-back reports never drop it within one step.
  task automatic send_report(report_t r);
    if (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(24, 1)) @(posedge clk);
    end
    in_bus.valid         <= 1'b1;
    in_bus.modifier_bits <= r.mods;
    in_bus.key_slot0     <= r.slots[0];
    in_bus.key_slot1     <= r.slots[1];
    in_bus.key_slot2     <= r.slots[2];
    in_bus.key_slot3     <= r.slots[3];
    in_bus.key_slot4     <= r.slots[4];
    in_bus.key_slot5     <= r.slots[5];
    do @(posedge clk); while (!in_bus.ready);
    predict_key_events(r);
    last_sent = r;
  endtask

  // A plausible next report: most slots keep their key, some empty out, some take
  // a fresh mapped key; rarely a slot copies another or takes any byte at all.
  function automatic report_t next_report(report_t prev);
    report_t     r;
    int unsigned roll;
    logic [7:0]  usage;
    r = prev;
    for (int b = 0; b < 8; b++)
      if ($urandom_range(99) < 15) r.mods[b] = ~r.mods[b];
    for (int i = 0; i < KEY_SLOTS; i++) begin
      roll = $urandom_range(99);
      if (roll < 55) begin
        r.slots[i] = prev.slots[i];
      end else if (roll < 70) begin
        r.slots[i] = 8'h00;
      end else if (roll < 92) begin
        do usage = 8'($urandom_range(8'h52, 8'h04)); while (set1_map[usage] == 0);
        r.slots[i] = usage;
      end else if (roll < 96) begin
        r.slots[i] = r.slots[$urandom_range(KEY_SLOTS - 1)];
      end else begin
        r.slots[i] = 8'($urandom_range(255));
      end
    end
    return r;
  endfunction

  // Start from the idle state, then walk every modifier edge both ways. GUI bits
  // alone must stay silent, and so must a report equal to the held one.
  task automatic test_modifier_edges();
    send_report(report(8'h00, 0, 0, 0, 0, 0, 0));
    send_report(report(8'h88, 0, 0, 0, 0, 0, 0));
    send_report(report(8'hFF, 0, 0, 0, 0, 0, 0));
    send_report(report(8'hFF, 0, 0, 0, 0, 0, 0));
    send_report(report(8'h00, 0, 0, 0, 0, 0, 0));
    send_report(report(8'h55, 0, 0, 0, 0, 0, 0));
    send_report(report(8'hAA, 0, 0, 0, 0, 0, 0));
  endtask

  // Table edges: first and last mapped usage, holes in the table, the error
  // codes 1..3, usages above the navigation keys (0x53 and 0xFF), and E0 keys.
  task automatic test_usage_table_edges();
    send_report(report(8'h00, 8'h04, 8'h52, 8'h01, 8'h02, 8'h03, 8'h53));
    send_report(report(8'h00, 8'hFF, 8'h48, 8'h32, 8'h49, 8'h29, 8'h2C));
    send_report(report(8'h00, 8'h45, 8'h44, 8'h39, 8'h47, 8'h46, 8'h4F));
    send_report(report(8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_report(report(8'h00, 0, 0, 0, 0, 0, 0));
  endtask

  // The same usage in several slots counts once per slot, on press and release.
  task automatic test_repeated_usage();
    send_report(report(8'h00, 8'h1E, 8'h1E, 8'h1E, 8'h1E, 8'h1E, 8'h1E));
    send_report(report(8'h00, 8'h1E, 8'h1E, 8'h00, 8'h00, 8'h00, 8'h00));
    send_report(report(8'h00, 8'h50, 8'h00, 8'h50, 8'h00, 8'h00, 8'h00));
    send_report(report(8'h00, 0, 0, 0, 0, 0, 0));
  endtask

  // Six modifier edges, six releases and six presses: the longest event burst.
  task automatic test_full_burst();
    send_report(report(8'h00, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09));
    send_report(report(8'h77, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h0E, 8'h0F));
    send_report(report(8'h00, 0, 0, 0, 0, 0, 0));
  endtask

  // Hold the receiver off while full bursts keep coming, so the output buffers
  // fill up and the block has to stall its input.
  task automatic test_output_backpressure();
    steady = 1'b1;
    hold_requests++;
    for (int n = 0; n < 6; n++) begin
      if (n % 2 == 0)
        send_report(report(8'h77, 8'h04, 8'h05, 8'h06, 8'h49, 8'h4A, 8'h52));
      else
        send_report(report(8'h00, 8'h1E, 8'h1F, 8'h20, 8'h4F, 8'h50, 8'h51));
    end
    steady = 1'b0;
  endtask

  // Mostly plausible report sequences with random content, some noise reports,
  // a stretch with no idling on either side and one more long receiver hold.
  task automatic test_random_reports(int unsigned count);
    report_t r;
    for (int n = 0; n < count; n++) begin
      steady = (n >= 30 && n < 60);
      if (n == 80) hold_requests++;
      if ($urandom_range(99) < 15) begin
        r.mods = 8'($urandom_range(255));
        for (int i = 0; i < KEY_SLOTS; i++) r.slots[i] = 8'($urandom_range(255));
      end else begin
        r = next_report(last_sent);
      end
      send_report(r);
    end
    steady = 1'b0;
  endtask

  initial begin
    in_bus.valid         = 1'b0;
    in_bus.modifier_bits = '0;
    in_bus.key_slot0     = '0;
    in_bus.key_slot1     = '0;
    in_bus.key_slot2     = '0;
    in_bus.key_slot3     = '0;
    in_bus.key_slot4     = '0;
    in_bus.key_slot5     = '0;
    out_bus.ready        = 1'b0;
    held_mods            = '0;
    held_keys            = '0;
    last_sent            = '0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_modifier_edges();
    test_usage_table_edges();
    test_repeated_usage();
    test_full_burst();
    test_output_backpressure();
    test_random_reports(85);

    // Drop valid, let the receiver take everything, then give the block time to
    // show any event nobody asked for.
    in_bus.valid <= 1'b0;
    steady = 1'b1;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("PASS hid_boot_report_to_set1_scancodes");
    else
      $display("FAIL hid_boot_report_to_set1_scancodes");
    $finish;
  end

  // Receiver: idle at random, stay ready in steady stretches, and count down a
  // long hold whenever a new one is requested.
  always @(posedge clk) begin
    if (hold_requests != holds_taken) begin
      holds_taken   <= hold_requests;
      hold_left     <= HOLD_CYCLES;
      out_bus.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Compare each key event transaction with the oldest one predicted.
  always @(posedge clk) begin : check_events
    key_event_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_events.size() == 0) begin
        $error("unexpected key event: scan_code %h is_extended %b is_press %b last_event %b",
               out_bus.scan_code, out_bus.is_extended, out_bus.is_press,
               out_bus.last_event);
        mismatches++;
      end else begin
        want = pending_events.pop_front();
        if (out_bus.scan_code !== want.scan_code) begin
          $error("scan_code: expected %h, actual %h", want.scan_code, out_bus.scan_code);
          mismatches++;
        end
        if (out_bus.is_extended !== want.is_extended) begin
          $error("is_extended: expected %b, actual %b", want.is_extended,
                 out_bus.is_extended);
          mismatches++;
        end
        if (out_bus.is_press !== want.is_press) begin
          $error("is_press: expected %b, actual %b", want.is_press, out_bus.is_press);
          mismatches++;
        end
        if (out_bus.last_event !== want.last_event) begin
          $error("last_event: expected %b, actual %b", want.last_event,
                 out_bus.last_event);
          mismatches++;
        end
      end
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #2_000_000;
    $display("FAIL hid_boot_report_to_set1_scancodes");
    $finish;
  end

endmodule
